### hw/rtl/rotation_matrix_to_quaternion_macros.svh
// Assertion macros for the rotation matrix to quaternion block.
// Used by the top level only; needs clk and rst_n in scope.
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`ifndef SYNTH
`define RMQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RMQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RMQ_ASSERT_NOW(lbl, ante, cons)
`define RMQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/rmq_pkg.sv
// Package for the rotation matrix to quaternion block: widths and stage types.
// No dependencies.
package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int IW = 16;                 // matrix entry width
  localparam int OW = 16;                 // result part width
  // magnitude width of an unnormalized part: |q| < 2^F + 3 * 2^15
  localparam int QMW = (FRAC_BITS > 17) ? FRAC_BITS + 1 : 18;
  localparam int QW  = QMW + 1;
  localparam int SW  = 2 * QMW + 2;       // sum of four squares
  localparam int RW  = 2 * QMW + 2 * FRAC_BITS + 8;
  localparam int NW  = FRAC_BITS + 1;     // rounded magnitude
  localparam int NST = FRAC_BITS + 1;     // one root stage per result bit

  typedef logic signed [QW-1:0] q_t;

  typedef struct packed {
    logic signed [RW-1:0] rem;  // target minus (2n-1)^2 * s
    logic signed [RW-1:0] es;   // (2n-1) * s
    logic [NW-1:0]        n;
    logic                 neg;
  } lane_t;

  typedef struct packed {
    lane_t [3:0]   lane;
    logic [SW-1:0] s;
    logic          zero;
  } root_t;

endpackage

### hw/rtl/rmq_ifs.sv
// Channel interfaces of the rotation matrix to quaternion block.
// Depends on rmq_pkg.
interface rmq_in_if import rmq_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [IW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                 input ready);
  modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
               output ready);
endinterface

interface rmq_out_if import rmq_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [OW-1:0] qx, qy, qz, qw;
  logic degenerate;
  modport source(output valid, qx, qy, qz, qw, degenerate, input ready);
  modport sink(input valid, qx, qy, qz, qw, degenerate, output ready);
endinterface

### hw/rtl/rmq_front.sv
// Front stages: branch select and raw quaternion, squares, sum and root seed.
// Depends on rmq_pkg and rmq_ifs.
module rmq_front import rmq_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  rmq_in_if.sink       in_word,
  output logic         out_valid,
  input  logic         out_ready,
  output root_t        out_data
);

  function automatic q_t sx(logic signed [IW-1:0] a);
    return {{(QW-IW){a[IW-1]}}, a};
  endfunction

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;
  q_t q1_r [4];
  q_t q1_nxt [4];
  logic [2*QMW-1:0] sq2_r [4];
  logic [3:0] neg2_r;
  root_t r3_r, r3_nxt;

  assign rdy3 = !v3_r || out_ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_word.ready = rdy1;

  // stage 1: trace test and branch formulas
  always_comb begin
    q_t e00, e01, e02, e10, e11, e12, e20, e21, e22, tr, one;
    e00 = sx(in_word.m00); e01 = sx(in_word.m01); e02 = sx(in_word.m02);
    e10 = sx(in_word.m10); e11 = sx(in_word.m11); e12 = sx(in_word.m12);
    e20 = sx(in_word.m20); e21 = sx(in_word.m21); e22 = sx(in_word.m22);
    one = q_t'(1) <<< FRAC_BITS;
    tr  = e00 + e11 + e22;
    priority if (tr > 0) begin
      q1_nxt[0] = e21 - e12; q1_nxt[1] = e02 - e20;
      q1_nxt[2] = e10 - e01; q1_nxt[3] = one + tr;
    end else if (e00 >= e11 && e00 >= e22) begin
      q1_nxt[0] = one + e00 - e11 - e22; q1_nxt[1] = e10 + e01;
      q1_nxt[2] = e20 + e02;             q1_nxt[3] = e21 - e12;
    end else if (e11 >= e22) begin
      q1_nxt[0] = e01 + e10;             q1_nxt[1] = one - e00 + e11 - e22;
      q1_nxt[2] = e21 + e12;             q1_nxt[3] = e02 - e20;
    end else begin
      q1_nxt[0] = e02 + e20;             q1_nxt[1] = e12 + e21;
      q1_nxt[2] = one - e00 - e11 + e22; q1_nxt[3] = e10 - e01;
    end
  end

  // stage 3: sum of squares and seed of the root recurrence (n = 0, e = -1)
  always_comb begin
    logic [SW-1:0] s;
    logic signed [RW-1:0] se;
    s = {2'b00, sq2_r[0]} + {2'b00, sq2_r[1]} + {2'b00, sq2_r[2]} + {2'b00, sq2_r[3]};
    se = {{(RW-SW){1'b0}}, s};
    r3_nxt.s    = s;
    r3_nxt.zero = (s == '0);
    for (int i = 0; i < 4; i++) begin
      r3_nxt.lane[i].rem = ({{(RW-2*QMW){1'b0}}, sq2_r[i]} <<< (2*FRAC_BITS+2)) - se;
      r3_nxt.lane[i].es  = -se;
      r3_nxt.lane[i].n   = '0;
      r3_nxt.lane[i].neg = neg2_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_word.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int i = 0; i < 4; i++) q1_r[i] <= q1_nxt[i];
    end
    if (rdy2) begin
      for (int i = 0; i < 4; i++) begin
        logic [QW-1:0] m;
        m = q1_r[i][QW-1] ? -q1_r[i] : q1_r[i];
        sq2_r[i]  <= m[QMW-1:0] * m[QMW-1:0];
        neg2_r[i] <= q1_r[i][QW-1];
      end
    end
    if (rdy3) r3_r <= r3_nxt;
  end

  assign out_valid = v3_r;
  assign out_data  = r3_r;

endmodule

### hw/rtl/rmq_root.sv
// Digit recurrence for round(|q| * 2^F / sqrt(s)): one result bit per stage.
// Depends on rmq_pkg.
module rmq_root import rmq_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  root_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output root_t out_data
);

  // try n + 2^b: accept if (2(n+2^b)-1)^2 * s <= |q|^2 * 2^(2F+2)
  function automatic lane_t step_lane(lane_t li, logic [SW-1:0] s, int b);
    lane_t lo;
    logic signed [RW-1:0] se, sub, diff;
    lo   = li;
    se   = {{(RW-SW){1'b0}}, s};
    sub  = (li.es <<< (b + 2)) + (se <<< (2 * b + 2));
    diff = li.rem - sub;
    if (!li.n[NW-1] && !diff[RW-1]) begin
      lo.rem = diff;
      lo.n   = li.n | (NW'(1) << b);
      lo.es  = li.es + (se <<< (b + 1));
    end
    return lo;
  endfunction

  root_t st_r [NST];
  logic [NST-1:0] v_r;
  logic [NST:0] rdy;

  assign rdy[NST] = out_ready;

  for (genvar k = 0; k < NST; k++) begin : g_stage
    root_t src, nxt;
    logic  src_v;
    if (k == 0) begin : g_first
      assign src   = in_data;
      assign src_v = in_valid;
    end else begin : g_next
      assign src   = st_r[k-1];
      assign src_v = v_r[k-1];
    end

    assign rdy[k] = !v_r[k] || rdy[k+1];

    always_comb begin
      nxt = src;
      for (int i = 0; i < 4; i++) nxt.lane[i] = step_lane(src.lane[i], src.s, FRAC_BITS - k);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) st_r[k] <= nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NST-1];
  assign out_data  = st_r[NST-1];

endmodule

### hw/rtl/rotation_matrix_to_quaternion.sv
// Rotation matrix to unit quaternion, Q2.14 matrix in, Q2.14 quaternion out.
// Pipeline: three front stages, one root stage per result bit, one output
// register. Throughput: one word per cycle while the output is ready; every
// stage holds a valid bit and stalls only when full.
// Reset: synchronous, active low; clears all valid bits, payload is not reset.
`include "rotation_matrix_to_quaternion_macros.svh"
module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  rmq_in_if.sink   in_word,
  rmq_out_if.source out_word
);

  // front -> root
  logic  f_valid, f_ready;
  root_t f_data;
  // root -> output register
  logic  r_valid, r_ready;
  root_t r_data;

  logic out_valid_r;
  logic signed [OW-1:0] q_r [4];
  logic signed [OW-1:0] q_nxt [4];
  logic degen_r;

  rmq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_data  (f_data)
  );

  rmq_root u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (r_valid),
    .out_ready (r_ready),
    .out_data  (r_data)
  );

  // output register: takes a new word whenever it is empty or being drained
  assign r_ready = !out_valid_r || out_word.ready;

  // restore signs; a zero-length quaternion gives all zeros
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic signed [RW-1:0] mag, val;
      mag = {{(RW-NW){1'b0}}, r_data.lane[i].n};
      val = r_data.lane[i].neg ? -mag : mag;
      q_nxt[i] = r_data.zero ? '0 : val[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (r_ready) begin
      out_valid_r <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r_ready) begin
      for (int i = 0; i < 4; i++) q_r[i] <= q_nxt[i];
      degen_r <= r_data.zero;
    end
  end

  assign out_word.valid      = out_valid_r;
  assign out_word.qx         = q_r[0];
  assign out_word.qy         = q_r[1];
  assign out_word.qz         = q_r[2];
  assign out_word.qw         = q_r[3];
  assign out_word.degenerate = degen_r;

  // degenerate words carry an all-zero quaternion
  `RMQ_ASSERT_NOW(a_degen_zero, out_valid_r && degen_r,
    q_r[0] == 0 && q_r[1] == 0 && q_r[2] == 0 && q_r[3] == 0)
  // a normalized quaternion always has some part of at least half scale
  `RMQ_ASSERT_NOW(a_nonzero, out_valid_r && !degen_r,
    q_r[0] != 0 || q_r[1] != 0 || q_r[2] != 0 || q_r[3] != 0)
  // a word held at the output keeps the root pipe's last stage from draining
  `RMQ_ASSERT_NEXT(a_hold, out_valid_r && !out_word.ready && r_valid, r_valid)

endmodule

### tb/rotation_matrix_to_quaternion_test.sv
// Testbench for rotation_matrix_to_quaternion: a directed table of matrices, then random
// matrices, each checked against a typed expectation or a bit-exact quaternion predictor. Depends
// on rmq_pkg and rmq_ifs (rmq_in_if, rmq_out_if) from the RTL.
module rotation_matrix_to_quaternion_test;
  import rmq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM   = 1880;
  localparam int IDLE_LIMIT = 4000;   // cycles with no word moving on either side
  localparam int DRAIN      = 40;     // wait after the last expected word has left
  localparam int N_DIR      = 18;

  typedef logic signed [IW-1:0] mat_t [9];   // m00 m01 m02 m10 m11 m12 m20 m21 m22

  typedef struct {
    logic signed [OW-1:0] qx, qy, qz, qw;
    logic                 degenerate;
  } quat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rmq_in_if  in_word();
  rmq_out_if out_word();

  rotation_matrix_to_quaternion dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word.sink),
    .out_word (out_word.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  quat_t quat_q[$];      // quaternions still owed by the pipeline
  int    errors = 0;
  int    idle_cycles = 0;
  int    cyc = 0;

  // Set by the driver with each word: a typed expectation replaces the predictor's.
  logic  use_typed = 1'b0;
  quat_t typed_quat;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Largest n <= 2^F with (2n-1)^2 * s <= 4 * q^2 * 2^(2F): |q| 2^F / sqrt(s), rounded
  // to nearest, halves away from zero.
  function automatic longint unsigned round_ratio(longint unsigned aq,
                                                  longint unsigned s);
    logic [127:0]    target, d, prod;
    longint unsigned n, c;
    n = 0;
    target = (128'(aq) * 128'(aq)) << (2 * FRAC_BITS + 2);
    for (int b = FRAC_BITS; b >= 0; b--) begin
      c = n + (64'd1 << b);
      if (c <= (64'd1 << FRAC_BITS)) begin
        d = 128'(2 * c - 1);
        prod = d * d * 128'(s);
        if (prod <= target) n = c;
      end
    end
    return n;
  endfunction

  function automatic quat_t quat_of(mat_t m);
    longint          a [9];
    longint          q [4];
    longint          one, tr, mx, n;
    longint unsigned s, mag;
    int              ix;
    quat_t           r;
    one = longint'(1) << FRAC_BITS;
    for (int i = 0; i < 9; i++) a[i] = longint'(m[i]);
    tr = a[0] + a[4] + a[8];
    if (tr > 0) begin
      q[0] = a[7] - a[5]; q[1] = a[2] - a[6]; q[2] = a[3] - a[1]; q[3] = one + tr;
    end else begin
      // largest diagonal picks the branch, ties to the lower index
      ix = 0; mx = a[0];
      if (a[4] > mx) begin mx = a[4]; ix = 1; end
      if (a[8] > mx) ix = 2;
      case (ix)
        0: begin
          q[0] = one + a[0] - a[4] - a[8]; q[1] = a[3] + a[1];
          q[2] = a[6] + a[2];              q[3] = a[7] - a[5];
        end
        1: begin
          q[0] = a[1] + a[3];              q[1] = one - a[0] + a[4] - a[8];
          q[2] = a[7] + a[5];              q[3] = a[2] - a[6];
        end
        default: begin
          q[0] = a[2] + a[6];              q[1] = a[5] + a[7];
          q[2] = one - a[0] - a[4] + a[8]; q[3] = a[3] - a[1];
        end
      endcase
    end
    s = 0;
    for (int i = 0; i < 4; i++) s += longint'(q[i] * q[i]);
    r.degenerate = (s == 0);
    if (s == 0) begin
      r.qx = '0; r.qy = '0; r.qz = '0; r.qw = '0;
      return r;
    end
    for (int i = 0; i < 4; i++) begin
      mag = round_ratio((q[i] < 0) ? -q[i] : q[i], s);
      n = (q[i] < 0) ? -longint'(mag) : longint'(mag);
      case (i)
        0: r.qx = OW'(n);
        1: r.qy = OW'(n);
        2: r.qz = OW'(n);
        default: r.qw = OW'(n);
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor and checker, all sampling at the rising edge
  // ---------------------------------------------------------------------------

  task automatic report(string field, longint got, longint want);
    errors++;
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cyc, field, got, want);
  endtask

  always @(posedge clk) begin
    quat_t want;
    mat_t  m;
    cyc++;
    if (rst_n) begin
      idle_cycles++;
      if (in_word.valid && in_word.ready) begin
        idle_cycles = 0;
        m = '{in_word.m00, in_word.m01, in_word.m02, in_word.m10, in_word.m11,
              in_word.m12, in_word.m20, in_word.m21, in_word.m22};
        quat_q.push_back(use_typed ? typed_quat : quat_of(m));
      end
      if (out_word.valid && out_word.ready) begin
        idle_cycles = 0;
        if (quat_q.size() == 0) begin
          errors++;
          $display("unexpected output word at cycle %0d", cyc);
        end else begin
          want = quat_q.pop_front();
          if (out_word.qx !== want.qx) report("qx", out_word.qx, want.qx);
          if (out_word.qy !== want.qy) report("qy", out_word.qy, want.qy);
          if (out_word.qz !== want.qz) report("qz", out_word.qz, want.qz);
          if (out_word.qw !== want.qw) report("qw", out_word.qw, want.qw);
          if (out_word.degenerate !== want.degenerate)
            report("degenerate", out_word.degenerate, want.degenerate);
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: nothing moved for %0d cycles", IDLE_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready changes on the falling edge; the mode steps in turn through
  // always ready, a fixed stall pattern, and random stalls.
  // ---------------------------------------------------------------------------

  initial out_word.ready = 1'b0;

  always @(negedge clk) begin
    case ((cyc / 256) % 4)
      0: out_word.ready <= 1'b1;
      1: out_word.ready <= (cyc % 7 != 3) && (cyc % 11 != 5);
      2: out_word.ready <= ($urandom_range(3, 0) != 0);
      default: out_word.ready <= ($urandom_range(1, 0) != 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Drive one word at the falling edge and hold it until the handshake.
  task automatic send(mat_t m);
    {in_word.m00, in_word.m01, in_word.m02} = {m[0], m[1], m[2]};
    {in_word.m10, in_word.m11, in_word.m12} = {m[3], m[4], m[5]};
    {in_word.m20, in_word.m21, in_word.m22} = {m[6], m[7], m[8]};
    in_word.valid = 1'b1;
    do @(posedge clk); while (!(in_word.valid && in_word.ready));
    @(negedge clk);
  endtask

  task automatic gap(int cycles);
    in_word.valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  function automatic logic signed [IW-1:0] rand_entry(int kind);
    case (kind)
      0: return IW'($urandom);                          // full range
      1: return IW'($urandom_range(32767, 0)) - 16'sd16384;  // within +-1.0 ish
      default: return IW'($urandom_range(64, 0)) - 16'sd32;  // near zero
    endcase
  endfunction

  mat_t  dir_m   [N_DIR];
  quat_t dir_q   [N_DIR];
  bit    dir_typ [N_DIR];

  localparam logic signed [IW-1:0] P1 = 16'sd16384;   // 1.0
  localparam logic signed [IW-1:0] M1 = -16'sd16384;  // -1.0
  localparam logic signed [IW-1:0] MX = 16'sd32767;
  localparam logic signed [IW-1:0] MN = -16'sd32768;

  initial begin
    mat_t m;
    int   burst, kind, diag_mode;
    // Directed rows: typed expectation only where it is plain.
    dir_m[0]  = '{P1, 0, 0, 0, P1, 0, 0, 0, P1};    // identity: w only
    dir_m[1]  = '{0, 0, 0, 0, 0, 0, 0, 0, 0};       // zero trace, tie to x branch
    dir_m[2]  = '{MN, 0, 0, 0, MN, 0, 0, 0, MN};    // negative diagonal, full tie
    dir_m[3]  = '{M1, 0, 0, 0, P1, 0, 0, 0, M1};    // half turn about y
    dir_m[4]  = '{M1, 0, 0, 0, M1, 0, 0, 0, P1};    // half turn about z
    dir_m[5]  = '{P1, 0, 0, 0, M1, 0, 0, 0, M1};    // half turn about x
    dir_m[6]  = '{MX, MX, MX, MX, MX, MX, MX, MX, MX};
    dir_m[7]  = '{MN, MN, MN, MN, MN, MN, MN, MN, MN};
    dir_m[8]  = '{MX, MN, MX, MN, MX, MN, MX, MN, MX};
    dir_m[9]  = '{MN, MX, MN, MX, MN, MX, MN, MX, MN};
    dir_m[10] = '{0, M1, 0, P1, 0, 0, 0, 0, P1};    // quarter turn about z
    dir_m[11] = '{0, 0, P1, 0, P1, 0, M1, 0, 0};    // quarter turn about y
    dir_m[12] = '{P1, 0, 0, 0, 0, M1, 0, P1, 0};    // quarter turn about x
    dir_m[13] = '{-16'sd1, MX, MN, MN, -16'sd1, MX, MX, MN, 16'sd1}; // trace just below 0
    dir_m[14] = '{16'sd1, MX, MN, MN, 0, MX, MX, MN, 0};             // trace of one lsb
    dir_m[15] = '{M1, 16'sd5, 16'sd3, 16'sd7, 16'sd100, 16'sd2, 16'sd1, 16'sd9, 16'sd100};
    dir_m[16] = '{16'sd100, 16'sd5, 16'sd3, 16'sd7, M1, 16'sd2, 16'sd1, 16'sd9, 16'sd100};
    dir_m[17] = '{16'sd11585, -16'sd11585, 0, 16'sd11585, 16'sd11585, 0, 0, 0, P1};
    for (int i = 0; i < N_DIR; i++) dir_typ[i] = 1'b0;
    dir_q[0] = '{qx: 0, qy: 0, qz: 0, qw: P1, degenerate: 0}; dir_typ[0] = 1'b1;
    dir_q[1] = '{qx: P1, qy: 0, qz: 0, qw: 0, degenerate: 0}; dir_typ[1] = 1'b1;
    dir_q[2] = '{qx: P1, qy: 0, qz: 0, qw: 0, degenerate: 0}; dir_typ[2] = 1'b1;
    dir_q[3] = '{qx: 0, qy: P1, qz: 0, qw: 0, degenerate: 0}; dir_typ[3] = 1'b1;
    dir_q[4] = '{qx: 0, qy: 0, qz: P1, qw: 0, degenerate: 0}; dir_typ[4] = 1'b1;
    dir_q[5] = '{qx: P1, qy: 0, qz: 0, qw: 0, degenerate: 0}; dir_typ[5] = 1'b1;

    in_word.valid = 1'b0;
    {in_word.m00, in_word.m01, in_word.m02} = '0;
    {in_word.m10, in_word.m11, in_word.m12} = '0;
    {in_word.m20, in_word.m21, in_word.m22} = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    // Directed table, with a short gap now and then.
    for (int i = 0; i < N_DIR; i++) begin
      use_typed  = dir_typ[i];
      typed_quat = dir_q[i];
      send(dir_m[i]);
      if (i % 5 == 4) gap(3);
    end
    use_typed = 1'b0;

    // Random part in bursts. Most words are near-unit matrices; the diagonal mode steers
    // into each branch and forces ties between diagonal entries.
    for (int i = 0; i < N_RANDOM; ) begin
      burst = $urandom_range(40, 1);
      for (int j = 0; j < burst && i < N_RANDOM; j++, i++) begin
        kind = ($urandom_range(9, 0) < 3) ? 0 : ($urandom_range(9, 0) < 8 ? 1 : 2);
        for (int k = 0; k < 9; k++) m[k] = rand_entry(kind);
        diag_mode = $urandom_range(7, 0);
        case (diag_mode)
          0: begin m[4] = m[0]; m[8] = m[0]; end                      // three-way tie
          1: m[4] = m[0];
          2: m[8] = m[4];
          3: begin m[0] = -m[4] - m[8]; end                           // trace near zero
          default: ;
        endcase
        send(m);
        // Hold off until the pipeline is empty once, mid-run.
        if (i == N_RANDOM / 2) begin
          in_word.valid = 1'b0;
          wait (quat_q.size() == 0);
          @(negedge clk);
        end
      end
      if ($urandom_range(3, 0) != 0) gap($urandom_range(12, 1));
    end
    in_word.valid = 1'b0;

    wait (quat_q.size() == 0);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && quat_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/rmq_pkg.sv
hw/rtl/rmq_ifs.sv
hw/rtl/rmq_front.sv
hw/rtl/rmq_root.sv
hw/rtl/rotation_matrix_to_quaternion.sv
tb/rotation_matrix_to_quaternion_test.sv
